// File: src/prdf_pkg.sv
// shared types, constants and widths for the pcm ring dma feeder
`default_nettype none

package prdf_pkg;

  // field widths
  localparam int OPCODE_W    = 3;
  localparam int SAMPLE_W    = 16;
  localparam int CLOCK_W     = 32;
  localparam int RATE_W      = 18;
  localparam int REQ_W       = 15;
  localparam int START_W     = 14;
  localparam int MAX_CHUNK_W = 12;
  localparam int BUFFERED_W  = 15;
  localparam int WORD_W      = 2 * SAMPLE_W;

  // clock arithmetic
  localparam int MS_PER_S = 1000;
  localparam int MS_W     = 10;
  localparam int PROD_W   = CLOCK_W + MS_W;

  localparam int HARD_CHUNK_CAP = 2048;

  // parameter defaults
  localparam int DEF_BUFFER_DEPTH = 16384;
  localparam int DEF_SILENCE_LEN  = 256;

  typedef enum logic [OPCODE_W-1:0] {
    OP_WRITE = 3'd0,
    OP_DMA   = 3'd1,
    OP_CLOCK = 3'd2,
    OP_FLUSH = 3'd3,
    OP_SPACE = 3'd4
  } opcode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_MUL,
    S_DIV_START,
    S_DIV_WAIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic exec;
    logic mul;
    logic div_start;
    logic finish;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_div;
    logic out_free;
    logic div_done;
  } dp_status_t;

endpackage

`default_nettype wire

// File: src/prdf_div.sv
// restoring divider, one quotient bit per cycle, for the sample clock
`default_nettype none

module prdf_div import prdf_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic [PROD_W-1:0]   dividend,
  input  wire logic [RATE_W-1:0]   divisor,
  output logic                     done,
  output logic [CLOCK_W-1:0]       quotient
);

  localparam int CNT_W = $clog2(PROD_W + 1);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [RATE_W-1:0] rem_r;
  logic [PROD_W-1:0] quo_r;
  logic [RATE_W-1:0] div_r;

  logic [RATE_W:0]   shifted;
  logic [RATE_W+1:0] diff;
  logic              fits;

  always_comb begin
    shifted = {rem_r, quo_r[PROD_W-1]};
    diff    = {1'b0, shifted} - {2'b00, div_r};
    fits    = ~diff[RATE_W+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CNT_W'(PROD_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      div_r <= divisor;
    end else if (busy_r) begin
      rem_r <= fits ? diff[RATE_W-1:0] : shifted[RATE_W-1:0];
      quo_r <= {quo_r[PROD_W-2:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r[CLOCK_W-1:0];

  // a new division never starts on top of a running one
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider restarted while busy");

endmodule

`default_nettype wire

// File: src/prdf_dp.sv
// datapath: ring pointers, sample store, clock registers, result register
`default_nettype none

module prdf_dp import prdf_pkg::*; #(
  parameter int BUFFER_DEPTH = DEF_BUFFER_DEPTH,
  parameter int SILENCE_LEN  = DEF_SILENCE_LEN
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire dp_cmd_t                       cmd,
  output dp_status_t                         status,
  input  wire logic [OPCODE_W-1:0]           in_opcode,
  input  wire logic signed [SAMPLE_W-1:0]    in_left_sample,
  input  wire logic signed [SAMPLE_W-1:0]    in_right_sample,
  input  wire logic [CLOCK_W-1:0]            in_base_ms,
  input  wire logic [RATE_W-1:0]             in_new_rate,
  input  wire logic [REQ_W-1:0]              in_request_count,
  input  wire logic                          cfg_we,
  input  wire logic [MAX_CHUNK_W-1:0]        cfg_max_chunk,
  input  wire logic                          out_ready,
  output logic                               out_valid,
  output logic                               out_accepted,
  output logic                               out_has_space,
  output logic [START_W-1:0]                 out_dma_start,
  output logic [MAX_CHUNK_W-1:0]             out_dma_len,
  output logic                               out_dma_silence,
  output logic [CLOCK_W-1:0]                 out_clock_ms,
  output logic [BUFFERED_W-1:0]              out_buffered
);

  localparam int SPAN  = 2 * BUFFER_DEPTH;
  localparam int PW    = $clog2(SPAN);
  localparam int IW    = $clog2(BUFFER_DEPTH);
  localparam int CMPW  = (PW > MAX_CHUNK_W) ? PW : MAX_CHUNK_W;
  localparam int SPW   = (PW > REQ_W) ? PW : REQ_W;
  localparam logic [PW:0]   SPAN_V  = (PW+1)'(SPAN);
  localparam logic [PW-1:0] DEPTH_V = PW'(BUFFER_DEPTH);

  // captured transaction
  logic [OPCODE_W-1:0] op_r;
  logic [SAMPLE_W-1:0] left_r;
  logic [SAMPLE_W-1:0] right_r;
  logic [CLOCK_W-1:0]  base_in_r;
  logic [RATE_W-1:0]   rate_in_r;
  logic [REQ_W-1:0]    req_r;

  // block state
  logic [PW-1:0]          rp_r, rp_nxt;
  logic [PW-1:0]          wp_r, wp_nxt;
  logic [CLOCK_W-1:0]     played_r, played_nxt;
  logic [CLOCK_W-1:0]     base_r, base_nxt;
  logic [RATE_W-1:0]      rate_r, rate_nxt;
  logic [CLOCK_W-1:0]     clock_r, clock_nxt;
  logic [MAX_CHUNK_W-1:0] max_chunk_r;
  logic [PROD_W-1:0]      product_r;
  logic                   out_valid_r, out_valid_nxt;

  logic [WORD_W-1:0] mem [BUFFER_DEPTH];
  logic              mem_we;
  logic [IW-1:0]     wr_idx;
  logic [IW-1:0]     rd_idx;

  // result register
  logic                   out_accepted_r;
  logic                   out_has_space_r;
  logic [START_W-1:0]     out_dma_start_r;
  logic [MAX_CHUNK_W-1:0] out_dma_len_r;
  logic                   out_dma_silence_r;
  logic [CLOCK_W-1:0]     out_clock_ms_r;
  logic [BUFFERED_W-1:0]  out_buffered_r;

  logic                   res_accepted;
  logic                   res_has_space;
  logic [START_W-1:0]     res_start;
  logic [MAX_CHUNK_W-1:0] res_len;
  logic                   res_silence;
  logic [CLOCK_W-1:0]     res_clock;
  logic [BUFFERED_W-1:0]  res_buffered;

  logic [PW-1:0]          used;
  logic [PW-1:0]          free_cnt;
  logic [PW-1:0]          rd_full;
  logic [PW-1:0]          to_end;
  logic [PW-1:0]          avail_lim;
  logic [MAX_CHUNK_W-1:0] cap;
  logic [CMPW-1:0]        chunk_w;
  logic [MAX_CHUNK_W-1:0] chunk;
  logic                   div_done;
  logic [CLOCK_W-1:0]     div_quot;

  // pointers wrap at twice the depth so full and empty differ
  function automatic logic [PW-1:0] ptr_add(input logic [PW-1:0] p, input logic [PW-1:0] n);
    logic [PW:0] s;
    s = {1'b0, p} + {1'b0, n};
    if (s >= SPAN_V) begin
      s = s - SPAN_V;
    end
    return s[PW-1:0];
  endfunction

  function automatic logic [PW-1:0] ptr_pos(input logic [PW-1:0] p);
    return (p >= DEPTH_V) ? (p - DEPTH_V) : p;
  endfunction

  always_comb begin
    logic [PW:0] t;
    t = {1'b0, wp_r} + ((wp_r < rp_r) ? SPAN_V : '0) - {1'b0, rp_r};
    used      = t[PW-1:0];
    free_cnt  = DEPTH_V - used;
    rd_full   = ptr_pos(rp_r);
    rd_idx    = IW'(rd_full);
    wr_idx    = IW'(ptr_pos(wp_r));
    to_end    = DEPTH_V - rd_full;
    avail_lim = (used < to_end) ? used : to_end;
    if (max_chunk_r == '0) begin
      cap = MAX_CHUNK_W'(1);
    end else if (max_chunk_r > MAX_CHUNK_W'(HARD_CHUNK_CAP)) begin
      cap = MAX_CHUNK_W'(HARD_CHUNK_CAP);
    end else begin
      cap = max_chunk_r;
    end
    chunk_w = (CMPW'(avail_lim) < CMPW'(cap)) ? CMPW'(avail_lim) : CMPW'(cap);
    chunk   = MAX_CHUNK_W'(chunk_w);
  end

  always_comb begin
    status.need_div = (op_r == OP_DMA) && (used != '0) && (rate_r != '0);
    status.out_free = !out_valid_r || out_ready;
    status.div_done = div_done;
  end

  always_comb begin
    rp_nxt        = rp_r;
    wp_nxt        = wp_r;
    played_nxt    = played_r;
    base_nxt      = base_r;
    rate_nxt      = rate_r;
    clock_nxt     = clock_r;
    mem_we        = 1'b0;
    res_accepted  = 1'b0;
    res_has_space = 1'b0;
    res_start     = '0;
    res_len       = '0;
    res_silence   = 1'b0;
    res_clock     = clock_r;
    res_buffered  = BUFFERED_W'(used);
    if (cmd.exec) begin
      case (op_r)
        OP_WRITE: begin
          if (used != DEPTH_V) begin
            mem_we       = 1'b1;
            wp_nxt       = ptr_add(wp_r, PW'(1));
            res_accepted = 1'b1;
            res_buffered = BUFFERED_W'(used + PW'(1));
          end
        end
        OP_DMA: begin
          if (used != '0) begin
            rp_nxt       = ptr_add(rp_r, PW'(chunk));
            played_nxt   = played_r + CLOCK_W'(chunk);
            res_start    = START_W'(rd_full);
            res_len      = chunk;
            res_buffered = BUFFERED_W'(used - PW'(chunk));
          end else begin
            res_len     = MAX_CHUNK_W'(SILENCE_LEN);
            res_silence = 1'b1;
          end
        end
        OP_FLUSH: begin
          rp_nxt       = '0;
          wp_nxt       = '0;
          played_nxt   = '0;
          base_nxt     = base_in_r;
          rate_nxt     = rate_in_r;
          clock_nxt    = base_in_r;
          res_clock    = base_in_r;
          res_buffered = '0;
        end
        OP_SPACE: begin
          res_has_space = (SPW'(free_cnt) >= SPW'(req_r));
        end
        default: begin
        end
      endcase
    end
    if (cmd.finish) begin
      clock_nxt = base_r + div_quot;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if ((cmd.exec && !status.need_div) || cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rp_r        <= '0;
      wp_r        <= '0;
      played_r    <= '0;
      base_r      <= '0;
      rate_r      <= '0;
      clock_r     <= '0;
      max_chunk_r <= MAX_CHUNK_W'(HARD_CHUNK_CAP);
      out_valid_r <= 1'b0;
    end else begin
      rp_r        <= rp_nxt;
      wp_r        <= wp_nxt;
      played_r    <= played_nxt;
      base_r      <= base_nxt;
      rate_r      <= rate_nxt;
      clock_r     <= clock_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        max_chunk_r <= cfg_max_chunk;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r      <= in_opcode;
      left_r    <= in_left_sample;
      right_r   <= in_right_sample;
      base_in_r <= in_base_ms;
      rate_in_r <= in_new_rate;
      req_r     <= in_request_count;
    end
    if (cmd.mul) begin
      product_r <= played_r * MS_W'(MS_PER_S);
    end
    if (cmd.exec) begin
      out_accepted_r    <= res_accepted;
      out_has_space_r   <= res_has_space;
      out_dma_start_r   <= res_start;
      out_dma_len_r     <= res_len;
      out_dma_silence_r <= res_silence;
      out_clock_ms_r    <= res_clock;
      out_buffered_r    <= res_buffered;
    end else if (cmd.finish) begin
      out_clock_ms_r    <= clock_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_idx] <= {right_r, left_r};
    end
  end

  prdf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (product_r),
    .divisor  (rate_r),
    .done     (div_done),
    .quotient (div_quot)
  );

  assign out_valid       = out_valid_r;
  assign out_accepted    = out_accepted_r;
  assign out_has_space   = out_has_space_r;
  assign out_dma_start   = out_dma_start_r;
  assign out_dma_len     = out_dma_len_r;
  assign out_dma_silence = out_dma_silence_r;
  assign out_clock_ms    = out_clock_ms_r;
  assign out_buffered    = out_buffered_r;

  // fill level never passes the depth
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used <= DEPTH_V)
    else $error("ring fill level above depth");

  // clock result is only finished with a fresh quotient
  a_finish_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> div_done)
    else $error("clock finished without divider result");

  // an item needing no division is presented in the next cycle
  a_direct_result: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && !status.need_div) |=> out_valid_r)
    else $error("result lost after execute");

endmodule

`default_nettype wire

// File: src/prdf_ctrl.sv
// controller state machine sequencing capture, execute and clock division
`default_nettype none

module prdf_ctrl import prdf_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire dp_status_t status,
  output dp_cmd_t         cmd
);

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (status.out_free) begin
          state_nxt = status.need_div ? S_MUL : S_IDLE;
        end
      end
      S_MUL:       state_nxt = S_DIV_START;
      S_DIV_START: state_nxt = S_DIV_WAIT;
      S_DIV_WAIT: begin
        if (status.div_done) begin
          state_nxt = S_IDLE;
        end
      end
      default:     state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      S_EXEC:      cmd.exec      = status.out_free;
      S_MUL:       cmd.mul       = 1'b1;
      S_DIV_START: cmd.div_start = 1'b1;
      S_DIV_WAIT:  cmd.finish    = status.div_done;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// File: src/pcm_ring_dma_feeder_with_clock_unit.sv
// top level of the pcm ring buffer dma feeder with sample clock
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+-------------------------------------
//  in_      | input     | in_valid / in_ready  | opcode, samples, base, rate, count
//  out_     | output    | out_valid/out_ready  | accepted, has_space, descriptor,
//           |           |                      | clock_ms, buffered
//  cfg_     | input     | cfg_valid/cfg_ready  | max_chunk
//
//  most transactions are captured, then executed into the result register
//  a dma request that moves samples while the rate is nonzero adds a multiply step,
//    then a restoring divider that retires one of 42 quotient bits per cycle
//  the next transaction is taken while a finished result still waits on out_ready;
//    execution stalls only while the result register is still occupied
//  rst_n is synchronous and active low; pointers, clock and max_chunk (2048) reset, no clearing pass
//  cfg writes are always taken (cfg_ready tied high) and should land only while idle
`default_nettype none

module pcm_ring_dma_feeder_with_clock_unit import prdf_pkg::*; #(
  parameter int BUFFER_DEPTH = DEF_BUFFER_DEPTH,
  parameter int SILENCE_LEN  = DEF_SILENCE_LEN
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // input transactions
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [OPCODE_W-1:0]         in_opcode,
  input  wire logic signed [SAMPLE_W-1:0]  in_left_sample,
  input  wire logic signed [SAMPLE_W-1:0]  in_right_sample,
  input  wire logic [CLOCK_W-1:0]          in_base_ms,
  input  wire logic [RATE_W-1:0]           in_new_rate,
  input  wire logic [REQ_W-1:0]            in_request_count,
  // result transactions
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic                             out_accepted,
  output logic                             out_has_space,
  output logic [START_W-1:0]               out_dma_start,
  output logic [MAX_CHUNK_W-1:0]           out_dma_len,
  output logic                             out_dma_silence,
  output logic [CLOCK_W-1:0]               out_clock_ms,
  output logic [BUFFERED_W-1:0]            out_buffered,
  // configuration write
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [MAX_CHUNK_W-1:0]      cfg_max_chunk
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // the chunk cap register has no side effects, so writes are never held off
  assign cfg_ready = 1'b1;

  // sequencing: capture -> execute -> optional multiply and divide for the clock
  prdf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // pointers, sample store, clock state and the result register
  prdf_dp #(
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .SILENCE_LEN  (SILENCE_LEN)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .in_opcode        (in_opcode),
    .in_left_sample   (in_left_sample),
    .in_right_sample  (in_right_sample),
    .in_base_ms       (in_base_ms),
    .in_new_rate      (in_new_rate),
    .in_request_count (in_request_count),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_max_chunk    (cfg_max_chunk),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_accepted     (out_accepted),
    .out_has_space    (out_has_space),
    .out_dma_start    (out_dma_start),
    .out_dma_len      (out_dma_len),
    .out_dma_silence  (out_dma_silence),
    .out_clock_ms     (out_clock_ms),
    .out_buffered     (out_buffered)
  );

endmodule

`default_nettype wire
